// File: src/srlm_pkg.sv
// Shared types and codes for the regex line matcher.
// Used by srlm_cell and simple_regex_line_matcher; no dependencies.

package srlm_pkg;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_MEMBER = 2'd2,
        MODE_TEXT   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        KIND_LIT    = 3'd0,
        KIND_ANY    = 3'd1,
        KIND_CLASS  = 3'd2,
        KIND_NCLASS = 3'd3,
        KIND_END    = 3'd4
    } kind_t;

    // Per-beat control broadcast to every cell of the chain
    typedef struct packed {
        logic       restart;   // end of line or pattern clear
        logic       step;      // nonzero text byte
        logic       at_end;    // text byte is zero
        logic       load;      // token append within capacity
        logic       member;    // class member add
        logic       clear;     // pattern clear
        logic [2:0] kind;
        logic       star;
        logic [7:0] data;
    } cell_ctrl_t;

endpackage

// File: src/simple_regex_line_matcher.sv
// Regex line matcher: one byte or pattern beat accepted per cycle, no bubbles, except that a
// line end is held while a result is stalled. A zero text byte yields its result in the output
// register in the cycle after acceptance; results are held while out_stall is high.
// All pattern positions update in parallel in a chain of MAX_TOKENS cells.
// Reset: empty pattern, empty class sets, unanchored, line restarted, no
// result pending. Depends on srlm_pkg and srlm_cell.

module simple_regex_line_matcher #(
    parameter int MAX_TOKENS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] mode,
    input  logic [2:0] token_kind,
    input  logic       star,
    input  logic [7:0] value,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       matched,
    output logic       pattern_overflow,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);

    localparam int CW = $clog2(MAX_TOKENS + 1);
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_TOKENS);

    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          anchor_reg;
    logic          line_start_reg, line_start_next;
    logic          seen_reg, seen_next;
    logic          act_last_reg, act_last_next;
    logic          out_valid_reg, out_valid_next;
    logic          matched_reg, matched_next;
    logic          out_ovf_reg, out_ovf_next;

    logic          accept;
    logic          is_eol;
    logic          eol;
    logic          match_now;
    srlm_pkg::cell_ctrl_t ctrl;

    logic [MAX_TOKENS:0]   cur_vec;
    logic [MAX_TOKENS:0]   carry;
    logic [MAX_TOKENS:0]   adv;

    assign is_eol   = (mode == srlm_pkg::MODE_TEXT) && (value == 8'd0);
    // Hold only a line end while the previous result is still stalled
    assign in_stall = out_valid_reg && out_stall && is_eol;
    assign accept   = in_valid && !in_stall;
    assign eol      = accept && is_eol;

    assign ctrl.restart = eol || (accept && mode == srlm_pkg::MODE_CLEAR);
    assign ctrl.step    = accept && mode == srlm_pkg::MODE_TEXT && value != 8'd0;
    assign ctrl.at_end  = (value == 8'd0);
    assign ctrl.load    = accept && mode == srlm_pkg::MODE_APPEND && count_reg < MAX_COUNT;
    assign ctrl.member  = accept && mode == srlm_pkg::MODE_MEMBER && !ovf_reg;
    assign ctrl.clear   = accept && mode == srlm_pkg::MODE_CLEAR;
    assign ctrl.kind    = token_kind;
    assign ctrl.star    = star;
    assign ctrl.data    = value;

    // New attempt at every byte unless anchored
    assign carry[0] = !anchor_reg || line_start_reg;
    assign adv[0]   = 1'b0;

    genvar g;
    generate
        for (g = 0; g < MAX_TOKENS; g++)
        begin : g_cell
            srlm_cell #(
                .INDEX (g),
                .CW    (CW)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (ctrl),
                .count   (count_reg),
                .cin     (carry[g]),
                .cout    (carry[g+1]),
                .adv_in  (adv[g]),
                .adv_out (adv[g+1]),
                .cur     (cur_vec[g])
            );
        end
    endgenerate

    assign cur_vec[MAX_TOKENS] = act_last_reg | carry[MAX_TOKENS];
    assign match_now           = cur_vec[count_reg];

    always_comb
    begin
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        line_start_next = line_start_reg;
        seen_next       = seen_reg;
        act_last_next   = act_last_reg;
        out_valid_next  = out_valid_reg && out_stall;
        matched_next    = matched_reg;
        out_ovf_next    = out_ovf_reg;

        if (ctrl.clear)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
        else if (accept && mode == srlm_pkg::MODE_APPEND)
        begin
            if (ctrl.load)
                count_next = count_reg + 1'b1;
            else
                ovf_next = 1'b1;
        end

        priority if (ctrl.restart)
        begin
            line_start_next = 1'b1;
            seen_next       = 1'b0;
            act_last_next   = 1'b0;
        end
        else if (ctrl.step)
        begin
            line_start_next = 1'b0;
            seen_next       = seen_reg | match_now;
            act_last_next   = adv[MAX_TOKENS];
        end
        else
        begin
            seen_next = seen_reg;
        end

        if (eol)
        begin
            out_valid_next = 1'b1;
            matched_next   = seen_reg | match_now;
            out_ovf_next   = ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            anchor_reg     <= 1'b0;
            line_start_reg <= 1'b1;
            seen_reg       <= 1'b0;
            act_last_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            line_start_reg <= line_start_next;
            seen_reg       <= seen_next;
            act_last_reg   <= act_last_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
                anchor_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        matched_reg <= matched_next;
        out_ovf_reg <= out_ovf_next;
    end

    assign cfg_ready        = 1'b1;
    assign out_valid        = out_valid_reg;
    assign matched          = matched_reg;
    assign pattern_overflow = out_ovf_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_COUNT)
        else $error("token count beyond capacity");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> count_reg == MAX_COUNT)
        else $error("overflow flag set with free token slots");

    a_eol_result: assert property (@(posedge clk) disable iff (!rst_n)
        eol |=> out_valid_reg)
        else $error("line end gave no result");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.clear |=> (count_reg == '0) && !ovf_reg && line_start_reg)
        else $error("pattern clear incomplete");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg && $stable(matched_reg))
        else $error("stalled result lost or changed");

endmodule

// File: src/srlm_cell.sv
// One pattern position of the matcher chain: token storage, class bitmap
// and the active bit of this position. Depends on srlm_pkg.

module srlm_cell #(
    parameter int INDEX = 0,
    parameter int CW    = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  srlm_pkg::cell_ctrl_t ctrl,
    input  logic [CW-1:0]       count,
    input  logic                cin,
    output logic                cout,
    input  logic                adv_in,
    output logic                adv_out,
    output logic                cur
);

    localparam logic [CW-1:0] IDX       = CW'(INDEX);
    localparam logic [CW-1:0] IDX_NEXT  = CW'(INDEX + 1);
    localparam logic [7:0]    UPPER_A   = 8'h41;
    localparam logic [7:0]    UPPER_Z   = 8'h5A;
    localparam logic [7:0]    CASE_STEP = 8'h20;

    logic [2:0]   kind_reg;
    logic         star_reg;
    logic [7:0]   char_reg;
    logic [255:0] class_reg;
    logic         active_reg;
    logic         active_next;

    logic         used;
    logic         pass;
    logic         take;
    logic [7:0]   folded;

    assign used   = (IDX < count);
    assign folded = (ctrl.data >= UPPER_A && ctrl.data <= UPPER_Z) ?
                    ctrl.data + CASE_STEP : ctrl.data;

    always_comb
    begin
        take = 1'b0;
        unique case (kind_reg)
            srlm_pkg::KIND_LIT:    take = (char_reg == ctrl.data) || (char_reg == folded);
            srlm_pkg::KIND_ANY:    take = 1'b1;
            srlm_pkg::KIND_CLASS:  take = class_reg[ctrl.data];
            srlm_pkg::KIND_NCLASS: take = !class_reg[ctrl.data];
            default:               take = 1'b0;
        endcase
    end

    // Positions passed without consuming a byte
    assign pass = (kind_reg == srlm_pkg::KIND_END) ? ctrl.at_end :
                  ((kind_reg <= srlm_pkg::KIND_NCLASS) && star_reg);

    assign cur     = active_reg | cin;
    assign cout    = cur & pass & used;
    assign adv_out = cur & take & used & !star_reg;

    always_comb
    begin
        active_next = active_reg;
        priority if (ctrl.restart)
            active_next = (INDEX == 0);
        else if (ctrl.step)
            active_next = (cur & take & used & star_reg) | adv_in;
        else
            active_next = active_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= (INDEX == 0);
            class_reg  <= '0;
        end
        else
        begin
            active_reg <= active_next;
            if (ctrl.clear)
                class_reg <= '0;
            else if (ctrl.member && count == IDX_NEXT)
                class_reg[ctrl.data] <= 1'b1;
        end
    end

    // Token fields are only read once written
    always_ff @(posedge clk)
    begin
        if (ctrl.load && count == IDX)
        begin
            kind_reg <= ctrl.kind;
            star_reg <= ctrl.star;
            char_reg <= ctrl.data;
        end
    end

endmodule
